>>> src/bucket_hash_insert_unique_core_assert.svh
// Assertion macros shared by the bucket hash insert design.
// Used by the top level; depends on nothing else.
`ifndef BUCKET_HASH_INSERT_UNIQUE_CORE_ASSERT_SVH
`define BUCKET_HASH_INSERT_UNIQUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BHIU_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BHIU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bhiu_pkg.sv
// Package for the bucket hash insert design: sizes, status codes, types.
// Used by every other file but the assert header; depends on nothing.
`timescale 1ns / 1ps

package bhiu_pkg;

  // Table geometry and stored field widths.
  localparam int SEL_BITS       = 10;
  localparam int SEL_START_BYTE = 1;
  localparam int SLOTS          = 4;
  localparam int SIG_BITS       = 64;
  localparam int KEY_BITS       = 64;
  localparam int ID_BITS        = 32;
  localparam int BYTE_RADIX     = 'h100;
  localparam int BYTE_W         = $clog2(BYTE_RADIX);

  // Port field widths.
  localparam int SIG_IN_W   = 64;
  localparam int KEY_IN_W   = 64;
  localparam int ID_IN_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int BUCKET_W   = 10;
  localparam int SLOT_OUT_W = 2;

  // The bucket index is a contiguous bit field of the signature: its last byte
  // is byte SEL_START_BYTE-1+(SEL_BITS-1)/8, counted from the most significant.
  localparam int SEL_LSB  = SIG_IN_W - BYTE_W * (SEL_START_BYTE + (SEL_BITS - 1) / BYTE_W);
  localparam int NBUCKETS = 1 << SEL_BITS;
  localparam int BKT_AW   = SEL_BITS;
  localparam int NENTRIES = NBUCKETS * SLOTS;
  localparam int ENT_AW   = (NENTRIES > 1) ? $clog2(NENTRIES) : 1;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SPILL     = 2'd2;

  typedef logic [BKT_AW-1:0] bkt_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ENT_AW-1:0] ent_addr_t;

  typedef struct packed {
    logic [SIG_BITS-1:0] sig;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } entry_t;

  // Request to the per-bucket fill count store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    bkt_t addr;
    cnt_t wdata;
  } cnt_cmd_t;

  // Request to the slot entry store.
  typedef struct packed {
    logic      rd_en;
    logic      wr_en;
    ent_addr_t addr;
    entry_t    wdata;
  } ent_cmd_t;

  function automatic bkt_t bucket_of(input logic [SIG_IN_W-1:0] sig);
    bucket_of = sig[SEL_LSB +: SEL_BITS];
  endfunction

endpackage

>>> src/bhiu_ifs.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on bhiu_pkg for the field widths.
`timescale 1ns / 1ps

interface bhiu_in_if;
  logic                             valid;
  logic                             ready;
  logic [bhiu_pkg::SIG_IN_W-1:0]    signature;
  logic [bhiu_pkg::KEY_IN_W-1:0]    public_key;
  logic [bhiu_pkg::ID_IN_W-1:0]     record_id;

  modport source (output valid, output signature, output public_key, output record_id,
                  input ready);
  modport sink   (input valid, input signature, input public_key, input record_id,
                  output ready);
endinterface

interface bhiu_out_if;
  logic                               valid;
  logic                               ready;
  logic [bhiu_pkg::STATUS_W-1:0]      status;
  logic [bhiu_pkg::BUCKET_W-1:0]      bucket;
  logic [bhiu_pkg::SLOT_OUT_W-1:0]    slot;

  modport source (output valid, output status, output bucket, output slot, input ready);
  modport sink   (input valid, input status, input bucket, input slot, output ready);
endinterface

>>> src/bhiu_count_store.sv
// Per-bucket fill count memory with a clearing sweep after reset.
// Depends on bhiu_pkg.
`timescale 1ns / 1ps

module bhiu_count_store (
  input  logic               clk,
  input  logic               rst_n,
  input  bhiu_pkg::cnt_cmd_t cmd,
  output bhiu_pkg::cnt_t     rdata,
  output logic               clearing
);

  // Slots fill in order and are never freed, so a count per bucket stands
  // for the presence bits of all its slots.
  bhiu_pkg::cnt_t mem [bhiu_pkg::NBUCKETS];
  bhiu_pkg::cnt_t rdata_r;
  logic           clr_r;
  logic           clr_nxt;
  bhiu_pkg::bkt_t clr_addr_r;
  bhiu_pkg::bkt_t clr_addr_nxt;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + bhiu_pkg::BKT_AW'(1);
      if (clr_addr_r == '1) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.addr];
    end
  end

  assign rdata    = rdata_r;
  assign clearing = clr_r;

endmodule

>>> src/bhiu_entry_store.sv
// Slot entry memory holding signature, key and id of each stored record.
// Depends on bhiu_pkg.
`timescale 1ns / 1ps

module bhiu_entry_store (
  input  logic               clk,
  input  bhiu_pkg::ent_cmd_t cmd,
  output bhiu_pkg::entry_t   rdata
);

  bhiu_pkg::entry_t mem [bhiu_pkg::NENTRIES];
  bhiu_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/bucket_hash_insert_unique_core.sv
// Top level of the bucketised hash table insert-if-absent block.
// Depends on bhiu_pkg, bhiu_ifs, bhiu_count_store, bhiu_entry_store and the assert header.
//
//   channel   | direction | carries
//   ----------+-----------+-----------------------------------------------
//   in_req    | sink      | signature, public_key, record_id
//   out_rsp   | source    | status, bucket, slot
//
// One request is worked on at a time. The single read port of the entry memory is
// walked one stored slot per cycle, so the scan grows with the bucket's fill count.
// After reset a clearing sweep zeroes the bucket fill counts, one bucket per cycle,
// for all NBUCKETS (1024) buckets; in_req.ready stays low meanwhile. The result sits in
// an output register, so the next request is taken while an earlier result waits.
`timescale 1ns / 1ps
`include "bucket_hash_insert_unique_core_assert.svh"

module bucket_hash_insert_unique_core (
  input logic        clk,
  input logic        rst_n,
  bhiu_in_if.sink    in_req,
  bhiu_out_if.source out_rsp
);

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_CNT  = 2'd1;  // fill count read data arrives
  localparam logic [1:0] S_SCAN = 2'd2;  // walk and compare the occupied slots
  localparam logic [1:0] S_DONE = 2'd3;  // hand the result to the output register

  logic [1:0] state_r, state_nxt;

  // The captured request. Signature, key and id are kept at their stored widths.
  logic [bhiu_pkg::SIG_BITS-1:0] sig_r, sig_nxt;
  logic [bhiu_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [bhiu_pkg::ID_BITS-1:0]  id_r, id_nxt;
  bhiu_pkg::bkt_t                bkt_r, bkt_nxt;

  // Scan bookkeeping: cnt_r is the number of occupied slots in the bucket,
  // scan_idx_r the next slot to read and cmp_idx_r the slot whose data is
  // arriving from the entry memory when cmp_vld_r is set.
  bhiu_pkg::cnt_t              cnt_r, cnt_nxt;
  bhiu_pkg::cnt_t              scan_idx_r, scan_idx_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [bhiu_pkg::SLOT_W-1:0] cmp_idx_r, cmp_idx_nxt;

  // The finished result, waiting for the output register to be free.
  logic [bhiu_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [bhiu_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [bhiu_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [bhiu_pkg::BUCKET_W-1:0]   out_bucket_r, out_bucket_nxt;
  logic [bhiu_pkg::SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;

  bhiu_pkg::cnt_cmd_t  cnt_cmd;
  bhiu_pkg::cnt_t      cnt_rdata;
  logic                clearing;
  bhiu_pkg::ent_cmd_t  ent_cmd;
  bhiu_pkg::entry_t    ent_rdata;
  bhiu_pkg::ent_addr_t ent_base;
  logic                accept;
  logic                sig_hit;

  bhiu_count_store u_count_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cnt_cmd),
    .rdata    (cnt_rdata),
    .clearing (clearing)
  );

  bhiu_entry_store u_entry_store (
    .clk   (clk),
    .cmd   (ent_cmd),
    .rdata (ent_rdata)
  );

  assign in_req.ready = (state_r == S_IDLE) && !clearing;
  assign accept       = in_req.valid && in_req.ready;

  // First entry of the bucket in the flat slot memory.
  assign ent_base = bhiu_pkg::ENT_AW'(bkt_r) * bhiu_pkg::ENT_AW'(bhiu_pkg::SLOTS);
  assign sig_hit  = cmp_vld_r && (ent_rdata.sig == sig_r);

  always_comb begin
    state_nxt      = state_r;
    sig_nxt        = sig_r;
    key_nxt        = key_r;
    id_nxt         = id_r;
    bkt_nxt        = bkt_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_bucket_nxt = out_bucket_r;
    out_slot_nxt   = out_slot_r;
    cnt_cmd        = '0;
    ent_cmd        = '0;

    // The consumer takes the pending result.
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sig_nxt       = bhiu_pkg::SIG_BITS'(in_req.signature);
          key_nxt       = bhiu_pkg::KEY_BITS'(in_req.public_key);
          id_nxt        = bhiu_pkg::ID_BITS'(in_req.record_id);
          bkt_nxt       = bhiu_pkg::bucket_of(in_req.signature);
          cnt_cmd.rd_en = 1'b1;
          cnt_cmd.addr  = bhiu_pkg::bucket_of(in_req.signature);
          state_nxt     = S_CNT;
        end
      end
      S_CNT: begin
        cnt_nxt      = cnt_rdata;
        scan_idx_nxt = '0;
        cmp_vld_nxt  = 1'b0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        if (sig_hit) begin
          // An occupied slot already holds this signature.
          res_status_nxt = bhiu_pkg::ST_DUPLICATE;
          res_slot_nxt   = cmp_idx_r;
          cmp_vld_nxt    = 1'b0;
          state_nxt      = S_DONE;
        end else if (scan_idx_r < cnt_r) begin
          // Issue the next occupied slot; its data is compared in the next cycle.
          ent_cmd.rd_en = 1'b1;
          ent_cmd.addr  = ent_base + bhiu_pkg::ENT_AW'(scan_idx_r);
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = bhiu_pkg::SLOT_W'(scan_idx_r);
          scan_idx_nxt  = scan_idx_r + bhiu_pkg::CNT_W'(1);
        end else if (cmp_vld_r) begin
          // The last compare missed; decide in the next cycle.
          cmp_vld_nxt = 1'b0;
        end else if (cnt_r < bhiu_pkg::CNT_W'(bhiu_pkg::SLOTS)) begin
          // No match: the first free slot is the one after the occupied ones.
          ent_cmd.wr_en     = 1'b1;
          ent_cmd.addr      = ent_base + bhiu_pkg::ENT_AW'(cnt_r);
          ent_cmd.wdata.sig = sig_r;
          ent_cmd.wdata.key = key_r;
          ent_cmd.wdata.id  = id_r;
          cnt_cmd.wr_en     = 1'b1;
          cnt_cmd.addr      = bkt_r;
          cnt_cmd.wdata     = cnt_r + bhiu_pkg::CNT_W'(1);
          res_status_nxt    = bhiu_pkg::ST_INSERTED;
          res_slot_nxt      = bhiu_pkg::SLOT_W'(cnt_r);
          state_nxt         = S_DONE;
        end else begin
          // Full bucket: the record spills and the table is left unchanged.
          res_status_nxt = bhiu_pkg::ST_SPILL;
          res_slot_nxt   = '0;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_bucket_nxt = bhiu_pkg::BUCKET_W'(bkt_r);
          out_slot_nxt   = bhiu_pkg::SLOT_OUT_W'(res_slot_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sig_r        <= sig_nxt;
    key_r        <= key_nxt;
    id_r         <= id_nxt;
    bkt_r        <= bkt_nxt;
    cnt_r        <= cnt_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_status_r;
  assign out_rsp.bucket = out_bucket_r;
  assign out_rsp.slot   = out_slot_r;

  // An accepted request always starts by fetching its bucket's fill count.
  `BHIU_ASSERT_NEXT(a_accept_fetches_count, clk, rst_n, accept, state_r == S_CNT, "accepted request did not move to count fetch")

  // A fill count update only accompanies an entry write into a bucket with room.
  `BHIU_ASSERT_IMPL(a_count_write_with_entry, clk, rst_n, cnt_cmd.wr_en, ent_cmd.wr_en && (cnt_r < bhiu_pkg::CNT_W'(bhiu_pkg::SLOTS)), "fill count written without a matching slot write")

  // The scan never runs past the occupied slots of the bucket.
  `BHIU_ASSERT_IMPL(a_scan_in_bounds, clk, rst_n, state_r == S_SCAN, (scan_idx_r <= cnt_r) && (cnt_r <= bhiu_pkg::CNT_W'(bhiu_pkg::SLOTS)), "slot scan out of bounds")

  // Nothing touches the table while the fill counts are being cleared.
  `BHIU_ASSERT_IMPL(a_idle_while_clearing, clk, rst_n, clearing, (state_r == S_IDLE) && !ent_cmd.rd_en && !ent_cmd.wr_en && !cnt_cmd.wr_en, "table accessed during clearing sweep")

endmodule
